// ===== design/afrs_pkg.sv =====
`timescale 1ns / 1ps

package afrs_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_OUT      = 32;

    localparam logic [31:0] AGE_LIMIT_RESET = 32'd300000;

    // command codes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_REBUILD = 2'd1;
    localparam logic [1:0] MODE_MOVE    = 2'd2;

    // step direction code that moves the selection down by one row
    localparam logic [1:0] STEP_NEXT = 2'b01;

    typedef struct packed {
        logic [7:0]        domain;
        logic [47:0]       mac;
        logic signed [7:0] rssi;
        logic [31:0]       seen;
    } entry_t;

    typedef struct packed {
        logic              row_valid;
        logic [4:0]        row_index;
        logic [7:0]        row_domain;
        logic [47:0]       row_mac;
        logic signed [7:0] row_rssi;
        logic [31:0]       row_seen_ms;
        logic [5:0]        row_total;
        logic              is_selected;
        logic [4:0]        sel_index;
        logic              moved;
        logic              last;
    } result_t;

    typedef struct packed {
        entry_t      cand;
        entry_t      key;
        logic        cand_before_key;
        logic [31:0] now;
        logic [31:0] age_limit;
    } rank_req_t;

    typedef struct packed {
        logic keep;
        logic ahead;
    } rank_rsp_t;

endpackage

// ===== design/afrs_in_if.sv =====
`timescale 1ns / 1ps

interface afrs_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [7:0]        dev_domain;
    logic [47:0]       dev_mac;
    logic signed [7:0] dev_rssi;
    logic [31:0]       seen_ms;
    logic [31:0]       now_ms;
    logic signed [1:0] step_dir;

    modport source (
        output valid, mode, dev_domain, dev_mac, dev_rssi, seen_ms, now_ms, step_dir,
        input  ready
    );

    modport sink (
        input  valid, mode, dev_domain, dev_mac, dev_rssi, seen_ms, now_ms, step_dir,
        output ready
    );
endinterface

// ===== design/afrs_out_if.sv =====
`timescale 1ns / 1ps

interface afrs_out_if;
    logic              valid;
    logic              ready;
    logic              row_valid;
    logic [4:0]        row_index;
    logic [7:0]        row_domain;
    logic [47:0]       row_mac;
    logic signed [7:0] row_rssi;
    logic [31:0]       row_seen_ms;
    logic [5:0]        row_total;
    logic              is_selected;
    logic [4:0]        sel_index;
    logic              moved;
    logic              last;

    modport source (
        output valid, row_valid, row_index, row_domain, row_mac, row_rssi, row_seen_ms,
               row_total, is_selected, sel_index, moved, last,
        input  ready
    );

    modport sink (
        input  valid, row_valid, row_index, row_domain, row_mac, row_rssi, row_seen_ms,
               row_total, is_selected, sel_index, moved, last,
        output ready
    );
endinterface

// ===== design/afrs_rank_unit.sv =====
`timescale 1ns / 1ps

// shared compare unit: age filter and stable descending rssi order
module afrs_rank_unit (
    input  afrs_pkg::rank_req_t req,
    output afrs_pkg::rank_rsp_t rsp
);

    logic [31:0] age;

    assign age       = req.now - req.cand.seen;
    assign rsp.keep  = (age <= req.age_limit);
    assign rsp.ahead = (req.cand.rssi > req.key.rssi) ||
                       ((req.cand.rssi == req.key.rssi) && req.cand_before_key);

endmodule

// ===== design/afrs_seq.sv =====
`timescale 1ns / 1ps

module afrs_seq #(
    parameter int CAPACITY = afrs_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         age_limit,
    afrs_in_if.sink             cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output afrs_pkg::result_t   res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = (CNT_W > 6) ? CNT_W : 6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY_RD,
        S_KEY_CHK,
        S_SW_RD,
        S_SW_CHK,
        S_PUT,
        S_PIN_START,
        S_PS_RD,
        S_PS_CHK,
        S_FIX,
        S_PIN_RD,
        S_PIN_SET,
        S_ROW_RD,
        S_ROW_DATA,
        S_EMPTY,
        S_MV_DATA
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]       m_reg, m_next;
    logic [CNT_W-1:0]       row_cnt_reg, row_cnt_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [IDX_W-1:0]       rank_reg, rank_next;
    logic [IDX_W-1:0]       sel_reg, sel_next;
    logic                   found_reg, found_next;
    logic                   moved_reg, moved_next;
    logic                   pin_valid_reg, pin_valid_next;
    logic [7:0]             pin_domain_reg, pin_domain_next;
    logic [47:0]            pin_mac_reg, pin_mac_next;
    afrs_pkg::entry_t       key_reg, key_next;
    logic [31:0]            now_reg, now_next;

    afrs_pkg::entry_t       ent_mem [CAPACITY];
    afrs_pkg::entry_t       row_mem [CAPACITY];
    afrs_pkg::entry_t       ent_rd_reg;
    afrs_pkg::entry_t       row_rd_reg;
    afrs_pkg::entry_t       new_entry;
    logic [IDX_W-1:0]       ent_addr;
    logic [IDX_W-1:0]       row_addr;
    logic                   ent_we;
    logic                   row_we;

    afrs_pkg::rank_req_t    rank_req;
    afrs_pkg::rank_rsp_t    rank_rsp;

    logic                   accept;
    logic [CNT_W-1:0]       sel_ext;
    logic [CNT_W-1:0]       i_inc;
    logic [CNT_W-1:0]       j_inc;
    logic [KW-1:0]          k_inc;
    logic                   i_done;
    logic                   j_done;
    logic                   k_last_pin;
    logic                   row_last;
    logic                   sel_in_list;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign new_entry.domain = cmd.dev_domain;
    assign new_entry.mac    = cmd.dev_mac;
    assign new_entry.rssi   = cmd.dev_rssi;
    assign new_entry.seen   = cmd.seen_ms;

    assign sel_ext     = CNT_W'(sel_reg);
    assign i_inc       = CNT_W'(i_reg) + CNT_W'(1);
    assign j_inc       = CNT_W'(j_reg) + CNT_W'(1);
    assign k_inc       = KW'(k_reg) + KW'(1);
    assign i_done      = (i_inc == load_cnt_reg);
    assign j_done      = (j_inc == load_cnt_reg);
    assign k_last_pin  = (k_inc == KW'(m_reg));
    assign row_last    = (k_inc == KW'(row_cnt_reg)) || (k_inc == KW'(afrs_pkg::MAX_OUT));
    assign sel_in_list = (sel_ext < row_cnt_reg);

    assign ent_we   = accept && (cmd.mode == afrs_pkg::MODE_LOAD) &&
                      (load_cnt_reg < CNT_W'(CAPACITY));
    assign ent_addr = (state_reg == S_KEY_RD) ? i_reg : j_reg;
    assign row_we   = (state_reg == S_PUT);
    assign row_addr = ((state_reg == S_PIN_RD) || (state_reg == S_IDLE) ||
                       (state_reg == S_MV_DATA)) ? sel_next : k_reg;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[load_cnt_reg[IDX_W-1:0]] <= new_entry;
        end
        ent_rd_reg <= ent_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[rank_reg] <= key_reg;
        end
        row_rd_reg <= row_mem[row_addr];
    end

    assign rank_req.cand            = ent_rd_reg;
    assign rank_req.key             = key_reg;
    assign rank_req.cand_before_key = (j_reg < i_reg);
    assign rank_req.now             = now_reg;
    assign rank_req.age_limit       = age_limit;

    afrs_rank_unit u_rank (
        .req (rank_req),
        .rsp (rank_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        m_next          = m_reg;
        row_cnt_next    = row_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        rank_next       = rank_reg;
        sel_next        = sel_reg;
        found_next      = found_reg;
        moved_next      = moved_reg;
        pin_valid_next  = pin_valid_reg;
        pin_domain_next = pin_domain_reg;
        pin_mac_next    = pin_mac_reg;
        key_next        = key_reg;
        now_next        = now_reg;

        res_valid       = 1'b0;
        res             = '0;
        res.row_total   = 6'(row_cnt_reg);
        res.sel_index   = 5'(sel_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.mode)
                        afrs_pkg::MODE_LOAD:
                        begin
                            if (ent_we)
                            begin
                                load_cnt_next = load_cnt_reg + CNT_W'(1);
                            end
                        end
                        afrs_pkg::MODE_REBUILD:
                        begin
                            now_next = cmd.now_ms;
                            i_next   = '0;
                            m_next   = '0;
                            state_next = (load_cnt_reg == '0) ? S_PIN_START : S_KEY_RD;
                        end
                        afrs_pkg::MODE_MOVE:
                        begin
                            moved_next = 1'b0;
                            if (cmd.step_dir == afrs_pkg::STEP_NEXT)
                            begin
                                if ((sel_ext + CNT_W'(1)) < row_cnt_reg)
                                begin
                                    sel_next   = sel_reg + IDX_W'(1);
                                    moved_next = 1'b1;
                                end
                            end
                            else if (cmd.step_dir[1])
                            begin
                                if ((sel_reg != '0) && ((sel_ext - CNT_W'(1)) < row_cnt_reg))
                                begin
                                    sel_next   = sel_reg - IDX_W'(1);
                                    moved_next = 1'b1;
                                end
                            end
                            state_next = S_MV_DATA;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // outer loop: fetch one load entry and test its age
            S_KEY_RD:
            begin
                state_next = S_KEY_CHK;
            end
            S_KEY_CHK:
            begin
                if (rank_rsp.keep)
                begin
                    key_next   = ent_rd_reg;
                    j_next     = '0;
                    rank_next  = '0;
                    state_next = S_SW_RD;
                end
                else if (i_done)
                begin
                    state_next = S_PIN_START;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_KEY_RD;
                end
            end

            // inner sweep: count kept entries that sort ahead of the key
            S_SW_RD:
            begin
                state_next = S_SW_CHK;
            end
            S_SW_CHK:
            begin
                if (rank_rsp.keep && rank_rsp.ahead)
                begin
                    rank_next = rank_reg + IDX_W'(1);
                end
                if (j_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_SW_RD;
                end
            end
            S_PUT:
            begin
                m_next = m_reg + CNT_W'(1);
                if (i_done)
                begin
                    state_next = S_PIN_START;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_KEY_RD;
                end
            end

            S_PIN_START:
            begin
                row_cnt_next  = m_reg;
                load_cnt_next = '0;
                k_next        = '0;
                found_next    = 1'b0;
                state_next    = (pin_valid_reg && (m_reg != '0)) ? S_PS_RD : S_FIX;
            end
            S_PS_RD:
            begin
                state_next = S_PS_CHK;
            end
            S_PS_CHK:
            begin
                if ((row_rd_reg.domain == pin_domain_reg) && (row_rd_reg.mac == pin_mac_reg))
                begin
                    sel_next   = k_reg;
                    found_next = 1'b1;
                    state_next = S_FIX;
                end
                else if (k_last_pin)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_PS_RD;
                end
            end
            S_FIX:
            begin
                k_next = '0;
                if (found_reg)
                begin
                    state_next = S_ROW_RD;
                end
                else if (m_reg == '0)
                begin
                    sel_next   = '0;
                    state_next = S_EMPTY;
                end
                else
                begin
                    if (sel_ext >= m_reg)
                    begin
                        sel_next = IDX_W'(m_reg - CNT_W'(1));
                    end
                    state_next = S_PIN_RD;
                end
            end
            S_PIN_RD:
            begin
                state_next = S_PIN_SET;
            end
            S_PIN_SET:
            begin
                pin_valid_next  = 1'b1;
                pin_domain_next = row_rd_reg.domain;
                pin_mac_next    = row_rd_reg.mac;
                state_next      = S_ROW_RD;
            end

            S_ROW_RD:
            begin
                state_next = S_ROW_DATA;
            end
            S_ROW_DATA:
            begin
                res_valid       = 1'b1;
                res.row_valid   = 1'b1;
                res.row_index   = 5'(k_reg);
                res.row_domain  = row_rd_reg.domain;
                res.row_mac     = row_rd_reg.mac;
                res.row_rssi    = row_rd_reg.rssi;
                res.row_seen_ms = row_rd_reg.seen;
                res.is_selected = (k_reg == sel_reg);
                res.last        = row_last;
                if (res_ready)
                begin
                    if (row_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_ROW_RD;
                    end
                end
            end
            S_EMPTY:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MV_DATA:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (sel_in_list)
                begin
                    res.row_valid   = 1'b1;
                    res.row_index   = 5'(sel_reg);
                    res.row_domain  = row_rd_reg.domain;
                    res.row_mac     = row_rd_reg.mac;
                    res.row_rssi    = row_rd_reg.rssi;
                    res.row_seen_ms = row_rd_reg.seen;
                    res.is_selected = 1'b1;
                    res.moved       = moved_reg;
                end
                if (res_ready)
                begin
                    if (moved_reg)
                    begin
                        pin_valid_next  = 1'b1;
                        pin_domain_next = row_rd_reg.domain;
                        pin_mac_next    = row_rd_reg.mac;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_cnt_reg   <= '0;
            m_reg          <= '0;
            row_cnt_reg    <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rank_reg       <= '0;
            sel_reg        <= '0;
            found_reg      <= 1'b0;
            moved_reg      <= 1'b0;
            pin_valid_reg  <= 1'b0;
            pin_domain_reg <= '0;
            pin_mac_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            m_reg          <= m_next;
            row_cnt_reg    <= row_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            rank_reg       <= rank_next;
            sel_reg        <= sel_next;
            found_reg      <= found_next;
            moved_reg      <= moved_next;
            pin_valid_reg  <= pin_valid_next;
            pin_domain_reg <= pin_domain_next;
            pin_mac_reg    <= pin_mac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        now_reg <= now_next;
    end

endmodule

// ===== design/age_filtered_rssi_sorter.sv =====
`timescale 1ns / 1ps

// channel   | dir  | handshake    | carries
// ----------+------+--------------+---------------------------------------------
// cmd       | sink | valid/ready  | mode, device entry, now_ms, step_dir
// rows      | src  | valid/ready  | one list row or status per transaction
// cfg       | sink | cfg_wr_en    | age_limit_ms, written with no wait
//
// a load is written into the load table while the block stays idle; a move reads
// the selected row and offers it through the output handshake; a rebuild ranks
// each kept entry by sweeping all loaded entries, searches the rows for the pin,
// then emits the rows; every rank step is one read of the load table through one compare
// reset clears the counts, the selection and the pin; no clearing pass is needed
// cmd.ready is low while a command runs; a stalled rows channel holds the block

module age_filtered_rssi_sorter #(
    parameter int CAPACITY = afrs_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    afrs_in_if.sink     cmd,
    afrs_out_if.source  rows
);

    // age limit register, reset to five minutes
    logic [31:0]        age_limit_reg;

    // handoff from the sequencer to the output register
    logic               res_valid;
    logic               res_ready;
    afrs_pkg::result_t  res;

    // output register parts the sequencer from the downstream stall
    logic               out_valid_reg;
    afrs_pkg::result_t  out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= afrs_pkg::AGE_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            age_limit_reg <= cfg_wr_data;
        end
    end

    // sort engine: load table, row store, rank unit and command sequencer
    afrs_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .age_limit (age_limit_reg),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // a new result may enter when the register is empty or is being drained
    assign res_ready = !out_valid_reg || rows.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_item_reg <= res;
        end
    end

    assign rows.valid       = out_valid_reg;
    assign rows.row_valid   = out_item_reg.row_valid;
    assign rows.row_index   = out_item_reg.row_index;
    assign rows.row_domain  = out_item_reg.row_domain;
    assign rows.row_mac     = out_item_reg.row_mac;
    assign rows.row_rssi    = out_item_reg.row_rssi;
    assign rows.row_seen_ms = out_item_reg.row_seen_ms;
    assign rows.row_total   = out_item_reg.row_total;
    assign rows.is_selected = out_item_reg.is_selected;
    assign rows.sel_index   = out_item_reg.sel_index;
    assign rows.moved       = out_item_reg.moved;
    assign rows.last        = out_item_reg.last;

    // the sequencer never offers a result while it takes commands
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.ready && res_valid))
        else $error("result offered while idle");

    // a moved selection always lands on a listed, selected row
    assert property (@(posedge clk) disable iff (!rst_n)
        (rows.valid && rows.moved) |-> (rows.is_selected && rows.row_valid))
        else $error("move result without selected row");

    // an emitted row lies inside the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (rows.valid && rows.row_valid && (rows.row_total != 6'd0)) |->
        ({1'b0, rows.row_index} < rows.row_total))
        else $error("row index beyond list length");

    // a result taken as the final one returns the block to accepting commands
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res.last) |=> cmd.ready)
        else $error("sequencer busy after final result");

endmodule
